@@ hw/rtl/per_worker_bump_allocator_unit_assert.svh @@
// Assertion macros used by the checker of the bump allocator.
`ifndef PER_WORKER_BUMP_ALLOCATOR_UNIT_ASSERT_SVH
`define PER_WORKER_BUMP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bump allocator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PWBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bump allocator assertion failed");

`endif

@@ hw/rtl/pwba_pkg.sv @@
// Shared types, codes and helpers of the per-worker bump allocator.
package pwba_pkg;

  localparam int DefWorkers    = 4;
  localparam int DefArenaBytes = 16384;

  // Width of the byte-offset fields on the ports and of the internal sums.
  localparam int FieldW = 21;
  localparam int SumW   = 23;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RESET   = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_QUERY   = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_ROOM  = 2'd1;
  localparam logic [1:0] STAT_BAD_MARK = 2'd2;

  localparam logic [2:0] ALIGN_DEFAULT = 3'd0;
  localparam logic [2:0] ALIGN_MAXED   = 3'd7;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [3:0]        worker_id;
    logic [FieldW-1:0] size_bytes;
    logic [2:0]        align_code;
    logic [FieldW-1:0] release_mark;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [FieldW-1:0] block_offset;
    logic [3:0]        worker_used;
    logic [FieldW-1:0] current_offset;
    logic [FieldW-1:0] peak_used;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted request word
    logic exec;  // serve the held request and fill the result register
  } cmd_t;

  // Alignment minus one: code zero is 8 bytes, seven saturates at 32 bytes.
  function automatic logic [4:0] align_mask(input logic [2:0] code);
    logic [4:0] m;
    m = 5'd0;
    unique case (code)
      ALIGN_DEFAULT: m = 5'd7;
      3'd1:          m = 5'd0;
      3'd2:          m = 5'd1;
      3'd3:          m = 5'd3;
      3'd4:          m = 5'd7;
      3'd5:          m = 5'd15;
      3'd6:          m = 5'd31;
      ALIGN_MAXED:   m = 5'd31;
      default:       m = 5'd31;
    endcase
    return m;
  endfunction

endpackage

@@ hw/rtl/pwba_ctrl.sv @@
// Controller state machine of the bump allocator: handshakes and sequencing.
module pwba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pwba_pkg::cmd_t  cmd_o
);
  import pwba_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   exec;

  assign in_ready_o  = (state_q == S_IDLE);
  // The result register must be empty or emptying before a new result lands.
  assign exec        = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign cmd_o.load  = in_valid_i && in_ready_o;
  assign cmd_o.exec  = exec;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/pwba_dp.sv @@
// Datapath of the bump allocator: offset registers, alignment, fit check, result.
module pwba_dp #(
  parameter int Workers    = pwba_pkg::DefWorkers,
  parameter int ArenaBytes = pwba_pkg::DefArenaBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pwba_pkg::cmd_t  cmd_i,
  input  pwba_pkg::req_t  req_i,
  output pwba_pkg::rsp_t  rsp_o
);
  import pwba_pkg::*;

  localparam int OffW = $clog2(ArenaBytes + 1);
  localparam int IdxW = (Workers > 1) ? $clog2(Workers) : 1;

  req_t            req_q;
  rsp_t            rsp_q, rsp_d;
  logic [OffW-1:0] bump_q [Workers];
  logic [OffW-1:0] peak_q, peak_d;
  logic [OffW-1:0] bump_new;
  logic            bump_we;

  logic [3:0]      wid;
  logic [IdxW-1:0] widx;
  logic [SumW-1:0] off_ext, mask_ext, base, blk_end;
  logic            fits;

  // Ids at or beyond the worker count are served as worker zero.
  always_comb begin
    wid = req_q.worker_id;
    if ({1'b0, req_q.worker_id} >= 5'(Workers)) begin
      wid = 4'd0;
    end
  end
  assign widx = wid[IdxW-1:0];

  assign off_ext  = SumW'(bump_q[widx]);
  assign mask_ext = SumW'(align_mask(req_q.align_code));
  assign base     = (off_ext + mask_ext) & ~mask_ext;
  assign blk_end  = base + SumW'(req_q.size_bytes);
  assign fits     = (blk_end <= SumW'(ArenaBytes));

  always_comb begin
    bump_new           = bump_q[widx];
    bump_we            = 1'b0;
    peak_d             = peak_q;
    rsp_d.status       = STAT_OK;
    rsp_d.block_offset = '0;
    unique case (req_q.req_type)
      REQ_ALLOC: begin
        if (fits) begin
          bump_new           = blk_end[OffW-1:0];
          bump_we            = 1'b1;
          rsp_d.block_offset = base[FieldW-1:0];
          if (blk_end[OffW-1:0] > peak_q) begin
            peak_d = blk_end[OffW-1:0];
          end
        end else begin
          rsp_d.status = STAT_NO_ROOM;
        end
      end
      REQ_RESET: begin
        bump_new = '0;
        bump_we  = 1'b1;
      end
      REQ_RELEASE: begin
        if (SumW'(req_q.release_mark) > off_ext) begin
          rsp_d.status = STAT_BAD_MARK;
        end else begin
          bump_new = req_q.release_mark[OffW-1:0];
          bump_we  = 1'b1;
        end
      end
      REQ_QUERY: begin
        bump_we = 1'b0;
      end
      default: bump_we = 1'b0;
    endcase
    rsp_d.worker_used    = wid;
    rsp_d.current_offset = FieldW'(bump_new);
    rsp_d.peak_used      = FieldW'(peak_d);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Workers; i++) begin
        bump_q[i] <= '0;
      end
      peak_q <= '0;
    end else if (cmd_i.exec) begin
      if (bump_we) begin
        bump_q[widx] <= bump_new;
      end
      peak_q <= peak_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

@@ hw/rtl/per_worker_bump_allocator_unit.sv @@
// Top level of the per-worker aligned bump allocator.
//
// Requests arrive as one word on in_valid_i/in_ready_o/in_data_i; every request
// gives exactly one result word on out_valid_o/out_ready_i/out_data_o. A word
// moves at a rising edge where valid and ready are both high.
// A request is captured in the cycle it is accepted and then served in the serve
// step, where the worker's offset register is read, aligned, checked against
// the arena size and written back, all in one pass. The result is registered,
// so out_valid_o rises once the serve step has filled the result register.
// The controller has a capture step and a serve step, and takes no new request
// while one is being served. A new request is taken while the previous result
// still waits; if the receiver stalls, the held request waits in the serve
// step until the result register frees, and in_ready_o stays low meanwhile.
// Reset clears all worker offsets and the overall peak to zero at once and
// empties the result register; no clearing pass is needed.
// Worker ids at or above Workers are served as worker zero.
module per_worker_bump_allocator_unit #(
  parameter int Workers    = pwba_pkg::DefWorkers,
  parameter int ArenaBytes = pwba_pkg::DefArenaBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pwba_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pwba_pkg::rsp_t  out_data_o
);
  import pwba_pkg::*;

  // Command word from the controller to the datapath.
  cmd_t cmd;

  // Sequencing and both handshakes.
  pwba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Offset state, alignment arithmetic and the result register.
  pwba_dp #(
    .Workers    (Workers),
    .ArenaBytes (ArenaBytes)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_data_i),
    .rsp_o  (out_data_o)
  );

endmodule

@@ hw/rtl/pwba_checker.sv @@
// Port-level checker of the bump allocator and its bind to the top level.
module pwba_checker #(
  parameter int Workers    = pwba_pkg::DefWorkers,
  parameter int ArenaBytes = pwba_pkg::DefArenaBytes
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input pwba_pkg::req_t  in_data_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input pwba_pkg::rsp_t  out_data_o
);
  import pwba_pkg::*;
  `include "per_worker_bump_allocator_unit_assert.svh"

  logic in_seen;
  logic refused;
  logic bounds_ok;
  logic worker_ok;

  assign in_seen   = in_valid_i && in_ready_o && (in_data_i.req_type != REQ_QUERY);
  assign refused   = out_valid_o && (out_data_o.status != STAT_OK);
  assign bounds_ok = (out_data_o.current_offset <= FieldW'(ArenaBytes)) &&
                     (out_data_o.peak_used >= out_data_o.current_offset);
  assign worker_ok = ({1'b0, out_data_o.worker_used} < 5'(Workers)) || !out_valid_o;

  // A stalled result word holds.
  `PWBA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // A refused request carries a zero block offset.
  `PWBA_ASSERT_NOW(a_blk_zero, refused, out_data_o.block_offset == '0)

  // Offsets stay inside the arena and never pass the peak.
  `PWBA_ASSERT_NOW(a_bounds, out_valid_o, bounds_ok)

  // The served worker is always a real arena.
  `PWBA_ASSERT_NOW(a_worker, out_valid_o || in_seen, worker_ok)

endmodule

bind per_worker_bump_allocator_unit pwba_checker #(
  .Workers    (Workers),
  .ArenaBytes (ArenaBytes)
) u_pwba_checker (.*);
